// File: rtl/core/csw_pkg.sv
// ----------------------------------------------------------------------------
// Class score window average package
// Shared widths, defaults, lane control bundle and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csw_pkg;

  localparam int SCORE_W          = 16;
  localparam int WLEN_W           = 7;
  localparam int CLASS_W          = 3;
  localparam int SCORE_PORTS      = 8;
  localparam int NUM_CLASSES_DEF  = 8;
  localparam int MAX_WINDOW_DEF   = 64;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

  typedef struct packed {
    logic write;
    logic update;
    logic clear;
    logic full;
  } csw_lane_ctrl_t;

  function automatic int csw_sum_w(input int max_window);
    return SCORE_W + $clog2(max_window);
  endfunction

  function automatic int csw_cnt_w(input int max_window);
    return $clog2(max_window + 1);
  endfunction

  function automatic int csw_pos_w(input int max_window);
    return $clog2(max_window);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/csw_lane.sv
// ----------------------------------------------------------------------------
// Class score lane
// Ring of recent scores for one class and its running window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_lane #(
  parameter int MAX_WINDOW = csw_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire csw_pkg::csw_lane_ctrl_t                        ctrl,
  input  wire logic [csw_pkg::csw_pos_w(MAX_WINDOW)-1:0]      pos,
  input  wire logic [csw_pkg::SCORE_W-1:0]                    score,
  output logic      [csw_pkg::csw_sum_w(MAX_WINDOW)-1:0]      sum
);
  import csw_pkg::*;

  localparam int SW = csw_sum_w(MAX_WINDOW);

  logic [SCORE_W-1:0] history [MAX_WINDOW];
  logic [SCORE_W-1:0] oldest;
  logic [SCORE_W-1:0] score_q;
  logic [SW-1:0]      sum_next;

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      history[pos] <= score;
      oldest       <= history[pos];
      score_q      <= score;
    end
  end

  always_comb begin
    sum_next = sum + SW'(score_q);
    if (ctrl.full) begin
      sum_next = sum_next - SW'(oldest);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.update) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/csw_merge.sv
// ----------------------------------------------------------------------------
// Class score merge
// Finds the largest lane sum, divides it by the item count bit by bit and
// picks the lowest class whose floored average equals the best one.
// ----------------------------------------------------------------------------
`default_nettype none

module csw_merge #(
  parameter int NUM_CLASSES = csw_pkg::NUM_CLASSES_DEF,
  parameter int MAX_WINDOW  = csw_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst,
  input  wire logic                                                   start,
  input  wire logic [csw_pkg::csw_cnt_w(MAX_WINDOW)-1:0]              count,
  input  wire logic [NUM_CLASSES-1:0][csw_pkg::csw_sum_w(MAX_WINDOW)-1:0] sums,
  output logic                                                        busy,
  output logic                                                        out_valid,
  input  wire logic                                                   out_ready,
  output logic      [csw_pkg::CLASS_W-1:0]                            best_class,
  output logic      [csw_pkg::SCORE_W-1:0]                            best_average
);
  import csw_pkg::*;

  localparam int SW  = csw_sum_w(MAX_WINDOW);
  localparam int CW  = csw_cnt_w(MAX_WINDOW);
  localparam int IW  = $clog2(NUM_CLASSES);
  localparam int DW  = $clog2(SCORE_W);

  typedef enum logic [2:0] {M_IDLE, M_SCAN, M_DIV, M_MUL, M_PICK} state_t;

  state_t                   state;
  logic [IW-1:0]            idx;
  logic [DW-1:0]            step;
  logic [SW-1:0]            maxv;
  logic [SW-1:0]            maxv_next;
  logic [SW-1:0]            cand;
  logic [CW-1:0]            rem;
  logic [SCORE_W-1:0]       quo;
  logic [CW:0]              trial;
  logic [CW:0]              diff;
  logic [SW-1:0]            thr;
  logic [SCORE_W+CW-1:0]    prod;
  logic [CLASS_W-1:0]       pick;
  logic                     emit;

  assign cand  = sums[idx];
  assign trial = {rem, quo[SCORE_W-1]};
  assign diff  = trial - {1'b0, count};
  assign prod  = quo * count;
  assign busy  = (state != M_IDLE);
  assign emit  = (state == M_PICK) && (!out_valid || out_ready);

  always_comb begin
    maxv_next = maxv;
    if (idx == '0 || cand > maxv) begin
      maxv_next = cand;
    end
  end

  always_comb begin
    pick = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (sums[c] >= thr) begin
        pick = CLASS_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= M_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      step      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        M_IDLE: begin
          if (start) begin
            idx   <= '0;
            state <= M_SCAN;
          end
        end
        M_SCAN: begin
          maxv <= maxv_next;
          if (idx == IW'(NUM_CLASSES - 1)) begin
            rem   <= CW'(maxv_next[SW-1:SCORE_W]);
            quo   <= maxv_next[SCORE_W-1:0];
            step  <= '0;
            state <= M_DIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        M_DIV: begin
          if (!diff[CW]) begin
            rem <= diff[CW-1:0];
            quo <= {quo[SCORE_W-2:0], 1'b1};
          end else begin
            rem <= trial[CW-1:0];
            quo <= {quo[SCORE_W-2:0], 1'b0};
          end
          if (step == DW'(SCORE_W - 1)) begin
            state <= M_MUL;
          end else begin
            step <= step + 1'b1;
          end
        end
        M_MUL: begin
          thr   <= prod[SW-1:0];
          state <= M_PICK;
        end
        M_PICK: begin
          if (emit) begin
            best_class   <= pick;
            best_average <= quo;
            state        <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/class_score_window_average_argmax_core.sv
// ----------------------------------------------------------------------------
// Class score window average with argmax
// Keeps a moving window of scores per class and reports the class with the
// highest floored window mean (lowest class on a tie), together with that mean.
// ----------------------------------------------------------------------------
// Each request carries one Q0.16 score per class. One lane per class writes
// the score into its ring and updates its window sum; a merge stage then scans
// the lane sums for the largest, divides it by the item count one quotient bit
// per cycle and picks the lowest class reaching that floored mean. A new
// request is accepted only once the block is idle again, which follows the
// scan over the lanes, the 16-step divider and the result hand-off. A finished
// result waits in an output register, so the next request can be processed
// while it is still held. Writing window_length, even with the same value,
// empties the window; it must only be written while the block is idle. A
// length of zero acts as one, and a length above MAX_WINDOW acts as
// MAX_WINDOW.
// ----------------------------------------------------------------------------
`default_nettype none

module class_score_window_average_argmax_core #(
  parameter int NUM_CLASSES = csw_pkg::NUM_CLASSES_DEF,
  parameter int MAX_WINDOW  = csw_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [csw_pkg::WLEN_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_0,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_1,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_2,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_3,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_4,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_5,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_6,
  input  wire logic [csw_pkg::SCORE_W-1:0]   score_7,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [csw_pkg::CLASS_W-1:0]   best_class,
  output logic      [csw_pkg::SCORE_W-1:0]   best_average
);
  import csw_pkg::*;

  localparam int SW = csw_sum_w(MAX_WINDOW);
  localparam int CW = csw_cnt_w(MAX_WINDOW);
  localparam int PW = csw_pos_w(MAX_WINDOW);

  typedef enum logic [1:0] {T_IDLE, T_UPDATE, T_WAIT} state_t;

  state_t                          state;
  logic [WLEN_W-1:0]               wlen;
  logic [CW-1:0]                   w_eff;
  logic [CW-1:0]                   items_seen;
  logic [PW-1:0]                   pos;
  logic [PW-1:0]                   wr_pos;
  logic [CW-1:0]                   pos_inc;
  logic [CW-1:0]                   n;
  logic [CW-1:0]                   items_inc;
  logic                            full;
  logic                            accept;
  logic                            merge_busy;
  logic [SCORE_W-1:0]              score_arr [SCORE_PORTS];
  logic [NUM_CLASSES-1:0][SW-1:0]  sums;
  csw_lane_ctrl_t                  lane_ctrl;

  assign score_arr[0] = score_0;
  assign score_arr[1] = score_1;
  assign score_arr[2] = score_2;
  assign score_arr[3] = score_3;
  assign score_arr[4] = score_4;
  assign score_arr[5] = score_5;
  assign score_arr[6] = score_6;
  assign score_arr[7] = score_7;

  always_comb begin
    priority if (wlen == '0) begin
      w_eff = CW'(1);
    end else if (wlen > MAX_WINDOW) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(wlen);
    end
  end

  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (items_seen >= w_eff);
  assign items_inc = items_seen + 1'b1;
  assign wr_pos    = (CW'(pos) >= w_eff) ? '0 : pos;
  assign pos_inc   = CW'(wr_pos) + 1'b1;

  assign lane_ctrl.write  = accept;
  assign lane_ctrl.update = (state == T_UPDATE);
  assign lane_ctrl.clear  = cfg_we;
  assign lane_ctrl.full   = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      wlen       <= WLEN_RESET;
      items_seen <= '0;
      pos        <= '0;
      n          <= '0;
    end else begin
      if (cfg_we) begin
        wlen       <= cfg_wdata;
        items_seen <= '0;
        pos        <= '0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            state <= T_UPDATE;
          end
        end
        T_UPDATE: begin
          if (!full) begin
            items_seen <= items_inc;
            n          <= items_inc;
          end else begin
            n <= w_eff;
          end
          pos   <= (pos_inc >= w_eff) ? '0 : pos_inc[PW-1:0];
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (!merge_busy) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
    csw_lane #(
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (lane_ctrl),
      .pos   (wr_pos),
      .score (score_arr[c]),
      .sum   (sums[c])
    );
  end

  csw_merge #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .start        (lane_ctrl.update),
    .count        (n),
    .sums         (sums),
    .busy         (merge_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .best_class   (best_class),
    .best_average (best_average)
  );

`ifndef SYNTHESIS
  a_items_in_window: assert property (@(posedge clk) disable iff (rst)
    items_seen <= w_eff)
    else $error("Item count exceeds the window length.");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    merge_busy |-> (n != '0))
    else $error("Merge stage running with a zero item count.");

  a_class_in_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (best_class < NUM_CLASSES))
    else $error("Reported class lies beyond the class count.");
`endif

endmodule

`default_nettype wire
